[src/pxt_pkg.sv]
// shared types, constants and latency helpers for the pose extrapolator
package pxt_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int AXES_PER_ITEM = 3;
	localparam int FACTOR_W = 24;
	localparam int FACTOR_MAX = 8388607;
	localparam int FACTOR_MIN = -8388608;
	localparam int CFG_W = 5;
	localparam int LANE_LAT = 3;
	localparam logic [3:0] SOFT_LIMIT_RST = 4'd3;
	localparam logic [4:0] ASYMPTOTE_RST = 5'd5;

	typedef enum logic {
		REG_SOFT_LIMIT,
		REG_ASYMPTOTE
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] prev_stamp;
		logic [31:0] cur_stamp;
		logic [31:0] now_stamp;
		logic signed [31:0] prev_a;
		logic signed [31:0] cur_a;
		logic signed [31:0] prev_b;
		logic signed [31:0] cur_b;
		logic signed [31:0] prev_c;
		logic signed [31:0] cur_c;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] out_a;
		logic signed [31:0] out_b;
		logic signed [31:0] out_c;
		logic signed [FACTOR_W-1:0] factor;
	} res_t;

	function automatic int div1_w(int f);
		return 32 + f;
	endfunction

	function automatic int div2_w(int f);
		return 9 + 2 * f;
	endfunction

	function automatic int factor_lat(int f);
		return div1_w(f) + div2_w(f) + 3;
	endfunction

	function automatic int total_lat(int f);
		return factor_lat(f) + LANE_LAT + 1;
	endfunction

endpackage

[src/pose_extrapolator.sv]
// pose extrapolator top level: config registers, lanes and result merge
// throughput: one item per cycle, busy never rises; depth is set by the two
// bit-per-stage divider pipelines in the factor path
// reset clears the valid line and loads soft_limit 3 and asymptote 5
// results come out on done for one cycle each; the receiver cannot stall
module pose_extrapolator #(
	parameter int FRAC_BITS = pxt_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  pxt_pkg::cmd_t               cmd,
	input  logic                        cfg_we,
	input  pxt_pkg::cfg_reg_t           cfg_idx,
	input  logic [pxt_pkg::CFG_W-1:0]   cfg_data,
	output logic                        done,
	output pxt_pkg::res_t               res
);

	localparam int AX = pxt_pkg::AXES_PER_ITEM;
	localparam int FLAT = pxt_pkg::factor_lat(FRAC_BITS);
	localparam int LLAT = FLAT + pxt_pkg::LANE_LAT;

	logic [3:0] soft_limit_q;
	logic [4:0] asymptote_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_limit_q <= pxt_pkg::SOFT_LIMIT_RST;
			asymptote_q <= pxt_pkg::ASYMPTOTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pxt_pkg::REG_SOFT_LIMIT: soft_limit_q <= cfg_data[3:0];
				pxt_pkg::REG_ASYMPTOTE:  asymptote_q <= cfg_data;
			endcase
		end
	end

	logic acc;
	assign busy = 1'b0;
	assign acc = start && !busy;

	logic [LLAT-1:0] vld_q;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q <= {vld_q[LLAT-2:0], acc};
			done_q <= vld_q[LLAT-1];
		end
	end

	logic signed [31:0] prev_v [AX];
	logic signed [31:0] cur_v [AX];
	assign prev_v[0] = cmd.prev_a;
	assign cur_v[0] = cmd.cur_a;
	assign prev_v[1] = cmd.prev_b;
	assign cur_v[1] = cmd.cur_b;
	assign prev_v[2] = cmd.prev_c;
	assign cur_v[2] = cmd.cur_c;

	logic signed [31:0] prev_dly_q [FLAT][AX];
	logic signed [31:0] cur_dly_q [FLAT][AX];

	always_ff @(posedge clk) begin
		prev_dly_q[0] <= prev_v;
		cur_dly_q[0] <= cur_v;
		for (int i = 1; i < FLAT; i++) begin
			prev_dly_q[i] <= prev_dly_q[i-1];
			cur_dly_q[i] <= cur_dly_q[i-1];
		end
	end

	logic signed [pxt_pkg::FACTOR_W-1:0] factor;

	pxt_factor #(.FRAC_BITS(FRAC_BITS)) u_factor (
		.clk(clk),
		.prev_stamp(cmd.prev_stamp),
		.cur_stamp(cmd.cur_stamp),
		.now_stamp(cmd.now_stamp),
		.soft_limit(soft_limit_q),
		.asymptote(asymptote_q),
		.factor(factor)
	);

	logic signed [31:0] lane_res [AX];

	for (genvar g = 0; g < AX; g++) begin : g_lane
		pxt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk),
			.prev(prev_dly_q[FLAT-1][g]),
			.cur(cur_dly_q[FLAT-1][g]),
			.factor(factor),
			.res(lane_res[g])
		);
	end

	logic signed [pxt_pkg::FACTOR_W-1:0] fac_dly_q [pxt_pkg::LANE_LAT];

	always_ff @(posedge clk) begin
		fac_dly_q[0] <= factor;
		for (int i = 1; i < pxt_pkg::LANE_LAT; i++) fac_dly_q[i] <= fac_dly_q[i-1];
	end

	pxt_pkg::res_t res_q;

	// merge lane results with the factor used
	always_ff @(posedge clk) begin
		res_q.out_a <= lane_res[0];
		res_q.out_b <= lane_res[1];
		res_q.out_c <= lane_res[2];
		res_q.factor <= fac_dly_q[pxt_pkg::LANE_LAT-1];
	end

	assign done = done_q;
	assign res = res_q;

endmodule

[src/pxt_div.sv]
// pipelined unsigned restoring divider, one quotient bit per stage
module pxt_div #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic [NW-1:0] q
);

	logic [NW-1:0] num_s [NW+1];
	logic [NW-1:0] quo_s [NW+1];
	logic [DW-1:0] rem_s [NW+1];
	logic [DW-1:0] den_s [NW+1];

	assign num_s[0] = n;
	assign quo_s[0] = '0;
	assign rem_s[0] = '0;
	assign den_s[0] = d;

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [DW:0] trial;
		logic        take;
		assign trial = {rem_s[g], num_s[g][NW-1]};
		assign take = trial >= {1'b0, den_s[g]};
		always_ff @(posedge clk) begin
			rem_s[g+1] <= take ? DW'(trial - {1'b0, den_s[g]}) : trial[DW-1:0];
			num_s[g+1] <= {num_s[g][NW-2:0], 1'b0};
			quo_s[g+1] <= {quo_s[g][NW-2:0], take};
			den_s[g+1] <= den_s[g];
		end
	end

	assign q = quo_s[NW];

endmodule

[src/pxt_factor.sv]
// extrapolation factor: time ratio, soft-limit bend and saturation
module pxt_factor #(
	parameter int FRAC_BITS = pxt_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic [31:0]                         prev_stamp,
	input  logic [31:0]                         cur_stamp,
	input  logic [31:0]                         now_stamp,
	input  logic [3:0]                          soft_limit,
	input  logic [4:0]                          asymptote,
	output logic signed [pxt_pkg::FACTOR_W-1:0] factor
);

	localparam int F = FRAC_BITS;
	localparam int N1 = pxt_pkg::div1_w(F);
	localparam int N2 = pxt_pkg::div2_w(F);
	localparam int W = (N1 > N2 ? N1 : N2) + 2;
	localparam int SW = N1 + 5;

	// stage 1: time differences and magnitudes
	logic [31:0] iv, el;
	assign iv = cur_stamp - prev_stamp;
	assign el = now_stamp - cur_stamp;

	logic          ez_s1, iz_s1, neg_s1;
	logic [N1-1:0] num1_s1;
	logic [31:0]   den1_s1;

	always_ff @(posedge clk) begin
		ez_s1 <= el == 32'd0;
		iz_s1 <= iv == 32'd0;
		neg_s1 <= el[31] ^ iv[31];
		num1_s1 <= {(el[31] ? 32'(-el) : el), {F{1'b0}}};
		den1_s1 <= iv[31] ? 32'(-iv) : iv;
	end

	logic [N1-1:0] q1;
	pxt_div #(.NW(N1), .DW(32)) u_div1 (.clk(clk), .n(num1_s1), .d(den1_s1), .q(q1));

	logic [2:0] side1_q [N1];
	always_ff @(posedge clk) begin
		side1_q[0] <= {ez_s1, iz_s1, neg_s1};
		for (int i = 1; i < N1; i++) side1_q[i] <= side1_q[i-1];
	end

	// stage 2: signed ratio, bend decision, bend numerator
	logic               neg_d;
	logic               bend;
	logic signed [N1:0] ext1;
	logic signed [5:0]  dlt;
	logic signed [10:0] p;
	logic [10:0]        pmag;

	assign neg_d = side1_q[N1-1][0];
	assign bend = !neg_d && (q1 > N1'({soft_limit, {F{1'b0}}}));
	assign ext1 = neg_d ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
	assign dlt = $signed({1'b0, asymptote}) - $signed({2'b00, soft_limit});
	assign p = $signed({7'b0, soft_limit}) * $signed({{5{dlt[5]}}, dlt});
	assign pmag = p[10] ? 11'(-p) : p;

	logic [N2-1:0]      num2_s2;
	logic [N1-1:0]      den2_s2;
	logic [SW-1:0]      side_s2;

	always_ff @(posedge clk) begin
		num2_s2 <= {pmag[8:0], {(2 * F){1'b0}}};
		den2_s2 <= q1;
		side_s2 <= {ext1, bend, side1_q[N1-1][2], side1_q[N1-1][1], p[10]};
	end

	logic [N2-1:0] q2;
	pxt_div #(.NW(N2), .DW(N1)) u_div2 (.clk(clk), .n(num2_s2), .d(den2_s2), .q(q2));

	logic [SW-1:0] side2_q [N2];
	always_ff @(posedge clk) begin
		side2_q[0] <= side_s2;
		for (int i = 1; i < N2; i++) side2_q[i] <= side2_q[i-1];
	end

	// stage 3: select, bend and saturate
	logic signed [N1:0]  ext1_d;
	logic                bend_d, ez_d, iz_d, psign_d;
	logic signed [W-1:0] asyw, q2w, bendv, extw, raw;

	assign {ext1_d, bend_d, ez_d, iz_d, psign_d} = side2_q[N2-1];
	assign asyw = $signed(W'({asymptote, {F{1'b0}}}));
	assign q2w = $signed(W'(q2));
	assign bendv = asyw - (psign_d ? -q2w : q2w);
	assign extw = W'(ext1_d);

	always_comb begin
		if (ez_d) raw = '0;
		else if (iz_d) raw = asyw;
		else if (bend_d) raw = bendv;
		else raw = extw;
	end

	always_ff @(posedge clk) begin
		if (raw > W'(pxt_pkg::FACTOR_MAX))
			factor <= pxt_pkg::FACTOR_W'(pxt_pkg::FACTOR_MAX);
		else if (raw < W'(pxt_pkg::FACTOR_MIN))
			factor <= pxt_pkg::FACTOR_W'(pxt_pkg::FACTOR_MIN);
		else
			factor <= raw[pxt_pkg::FACTOR_W-1:0];
	end

endmodule

[src/pxt_lane.sv]
// one axis lane: delta times factor, floor scaling, add and saturate
module pxt_lane #(
	parameter int FRAC_BITS = pxt_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic signed [31:0]                  prev,
	input  logic signed [31:0]                  cur,
	input  logic signed [pxt_pkg::FACTOR_W-1:0] factor,
	output logic signed [31:0]                  res
);

	localparam int PW = 33 + pxt_pkg::FACTOR_W;
	localparam logic signed [PW:0] RMAX = (PW + 1)'(64'sd2147483647);
	localparam logic signed [PW:0] RMIN = (PW + 1)'(-64'sd2147483648);

	logic signed [32:0]                  diff_s1;
	logic signed [31:0]                  cur_s1, cur_s2;
	logic signed [pxt_pkg::FACTOR_W-1:0] fac_s1;
	logic signed [PW-1:0]                prod_s2;

	always_ff @(posedge clk) begin
		diff_s1 <= $signed({cur[31], cur}) - $signed({prev[31], prev});
		cur_s1 <= cur;
		fac_s1 <= factor;
		prod_s2 <= diff_s1 * fac_s1;
		cur_s2 <= cur_s1;
	end

	logic signed [PW-1:0] sh;
	logic signed [PW:0]   sum;
	assign sh = prod_s2 >>> FRAC_BITS;
	assign sum = (PW + 1)'(sh) + (PW + 1)'(cur_s2);

	always_ff @(posedge clk) begin
		if (sum > RMAX) res <= 32'sh7fffffff;
		else if (sum < RMIN) res <= 32'sh80000000;
		else res <= sum[31:0];
	end

endmodule

[src/pxt_checker.sv]
// port-level checks for the pose extrapolator and their bind
module pxt_checker #(
	parameter int FRAC_BITS = pxt_pkg::FRAC_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input pxt_pkg::cmd_t cmd,
	input logic          done,
	input pxt_pkg::res_t res
);

	localparam int TL = pxt_pkg::total_lat(FRAC_BITS);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##TL done)
		else $error("transfer without result");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TL))
		else $error("result without transfer");

	a_zero_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && cmd.now_stamp == cmd.cur_stamp, TL) |->
		res.factor == '0 && res.out_a == $past(cmd.cur_a, TL))
		else $error("zero elapsed time not passed through");

endmodule

bind pose_extrapolator pxt_checker #(.FRAC_BITS(FRAC_BITS)) u_pxt_checker (.*);
